// ===== rtl/core/umrx_pkg.sv =====
// ----------------------------------------------------------------------------
// umrx_pkg
// shared types and constants of the universal machine register execute unit
// ----------------------------------------------------------------------------
package umrx_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned RIDX_W    = 3;
  localparam int unsigned ACT_W     = 4;
  localparam int unsigned OPC_W     = 4;
  localparam int unsigned OPC_LSB   = 28;
  localparam int unsigned LV_REG_LSB = 25;
  localparam int unsigned LV_W      = 25;
  localparam int unsigned DIV_CNT_W = 5;
  localparam logic [XLEN-1:0] CHAR_MAX = 32'd255;

  localparam logic [OPC_W-1:0] OPC_CMOV    = 4'd0;
  localparam logic [OPC_W-1:0] OPC_LOAD    = 4'd1;
  localparam logic [OPC_W-1:0] OPC_STORE   = 4'd2;
  localparam logic [OPC_W-1:0] OPC_ADD     = 4'd3;
  localparam logic [OPC_W-1:0] OPC_MUL     = 4'd4;
  localparam logic [OPC_W-1:0] OPC_DIV     = 4'd5;
  localparam logic [OPC_W-1:0] OPC_NAND    = 4'd6;
  localparam logic [OPC_W-1:0] OPC_HALT    = 4'd7;
  localparam logic [OPC_W-1:0] OPC_MAP     = 4'd8;
  localparam logic [OPC_W-1:0] OPC_UNMAP   = 4'd9;
  localparam logic [OPC_W-1:0] OPC_OUT     = 4'd10;
  localparam logic [OPC_W-1:0] OPC_IN      = 4'd11;
  localparam logic [OPC_W-1:0] OPC_LOADPRG = 4'd12;
  localparam logic [OPC_W-1:0] OPC_LOADVAL = 4'd13;

  localparam logic [ACT_W-1:0] ACT_NONE     = 4'd0;
  localparam logic [ACT_W-1:0] ACT_READ     = 4'd1;
  localparam logic [ACT_W-1:0] ACT_WRITE    = 4'd2;
  localparam logic [ACT_W-1:0] ACT_MAP      = 4'd3;
  localparam logic [ACT_W-1:0] ACT_UNMAP    = 4'd4;
  localparam logic [ACT_W-1:0] ACT_OUT      = 4'd5;
  localparam logic [ACT_W-1:0] ACT_IN       = 4'd6;
  localparam logic [ACT_W-1:0] ACT_LOADPROG = 4'd7;
  localparam logic [ACT_W-1:0] ACT_HALT     = 4'd8;
  localparam logic [ACT_W-1:0] ACT_DIV0     = 4'd9;
  localparam logic [ACT_W-1:0] ACT_BADCHAR  = 4'd10;
  localparam logic [ACT_W-1:0] ACT_PROTOCOL = 4'd11;

  typedef struct packed {
    logic capture;
    logic rd_a;
    logic latch_bc;
    logic latch_a;
    logic div_start;
    logic div_step;
    logic commit;
  } umrx_cmd_t;

  typedef struct packed {
    logic skip_read;
    logic need_div;
    logic div_last;
    logic out_free;
  } umrx_sts_t;

endpackage

// ===== rtl/core/umrx_ram.sv =====
// ----------------------------------------------------------------------------
// umrx_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module umrx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr0,
  input  logic [$clog2(DEPTH)-1:0] rd_addr1,
  output logic [WIDTH-1:0]         rd_data0,
  output logic [WIDTH-1:0]         rd_data1
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data0 <= mem_r[rd_addr0];
    rd_data1 <= mem_r[rd_addr1];
  end

endmodule

// ===== rtl/core/umrx_ctrl.sv =====
// ----------------------------------------------------------------------------
// umrx_ctrl
// sequencer: operand reads, divide iterations and result commit
// ----------------------------------------------------------------------------
module umrx_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  umrx_pkg::umrx_sts_t sts,
  output umrx_pkg::umrx_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RDBC = 3'd1;
  localparam logic [2:0] ST_RDA  = 3'd2;
  localparam logic [2:0] ST_EXEC = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_RDBC;
        end
      end
      ST_RDBC: begin
        state_nxt = sts.skip_read ? ST_DONE : ST_RDA;
      end
      ST_RDA: begin
        cmd.rd_a     = 1'b1;
        cmd.latch_bc = 1'b1;
        state_nxt    = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.latch_a = 1'b1;
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_RDBC))
    else $error("accepted item did not start operand read");

  a_commit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> in_tready)
    else $error("commit not followed by idle");

endmodule

// ===== rtl/core/umrx_datapath.sv =====
// ----------------------------------------------------------------------------
// umrx_datapath
// register file, program counter, divider, decode and result register
// ----------------------------------------------------------------------------
module umrx_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  umrx_pkg::umrx_cmd_t cmd,
  output umrx_pkg::umrx_sts_t sts,
  input  logic                in_op,
  input  logic [31:0]         in_instruction,
  input  logic [31:0]         in_response,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_action,
  output logic [31:0]         out_segment_id,
  output logic [31:0]         out_word_offset,
  output logic [31:0]         out_data_value,
  output logic [31:0]         out_next_pc
);

  localparam int unsigned XL = umrx_pkg::XLEN;
  localparam int unsigned RW = umrx_pkg::RIDX_W;

  logic          op_r;
  logic [XL-1:0] instr_r;
  logic [XL-1:0] resp_r;
  logic [XL-1:0] rb_r;
  logic [XL-1:0] rc_r;
  logic [XL-1:0] ra_r;
  logic [XL-1:0] pc_r;
  logic [XL-1:0] pc_nxt;
  logic [RW-1:0] pend_r;
  logic [RW-1:0] pend_nxt;
  logic          await_r;
  logic          await_nxt;
  logic          halted_r;
  logic          halted_nxt;
  logic [umrx_pkg::NUM_REGS-1:0] vld_r;

  logic [XL-1:0] quot_r;
  logic [XL-1:0] rem_r;
  logic [umrx_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [XL:0]   rem_sh;
  logic [XL:0]   rem_diff;

  logic                 out_valid_r;
  logic [3:0]           act_r;
  logic [XL-1:0]        seg_r;
  logic [XL-1:0]        off_r;
  logic [XL-1:0]        dat_r;
  logic [XL-1:0]        npc_r;

  logic [umrx_pkg::OPC_W-1:0] opc;
  logic [RW-1:0] fa;
  logic [RW-1:0] fb;
  logic [RW-1:0] fc;
  logic [RW-1:0] flv;
  logic          blocked;

  logic [XL-1:0] rd0;
  logic [XL-1:0] rd1;
  logic [RW-1:0] rd_addr0;
  logic [XL-1:0] prod;

  logic [3:0]    act;
  logic [XL-1:0] seg;
  logic [XL-1:0] off;
  logic [XL-1:0] dat;
  logic          we;
  logic [RW-1:0] wa;
  logic [XL-1:0] wd;

  assign opc = instr_r[XL-1 -: umrx_pkg::OPC_W];
  assign fa  = instr_r[8:6];
  assign fb  = instr_r[5:3];
  assign fc  = instr_r[2:0];
  assign flv = instr_r[umrx_pkg::LV_REG_LSB +: RW];

  assign blocked = op_r ? (halted_r || !await_r) : (halted_r || await_r);

  assign rd_addr0 = cmd.rd_a ? fa : fb;

  umrx_ram #(
    .WIDTH (XL),
    .DEPTH (umrx_pkg::NUM_REGS)
  ) u_rf (
    .clk      (clk),
    .wr_en    (we && cmd.commit),
    .wr_addr  (wa),
    .wr_data  (wd),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (fc),
    .rd_data0 (rd0),
    .rd_data1 (rd1)
  );

  assign prod     = rb_r * rc_r;
  assign rem_sh   = {rem_r, quot_r[XL-1]};
  assign rem_diff = rem_sh - {1'b0, rc_r};

  assign sts.skip_read = op_r || blocked;
  assign sts.need_div  = (opc == umrx_pkg::OPC_DIV) && (rc_r != '0);
  assign sts.div_last  = (div_cnt_r == '1);
  assign sts.out_free  = !out_valid_r || out_ready;

  always_comb begin
    act        = umrx_pkg::ACT_NONE;
    seg        = '0;
    off        = '0;
    dat        = '0;
    we         = 1'b0;
    wa         = fa;
    wd         = '0;
    pc_nxt     = pc_r;
    pend_nxt   = pend_r;
    await_nxt  = await_r;
    halted_nxt = halted_r;
    if (blocked) begin
      act = umrx_pkg::ACT_PROTOCOL;
    end else if (op_r) begin
      we        = 1'b1;
      wa        = pend_r;
      wd        = resp_r;
      await_nxt = 1'b0;
    end else begin
      pc_nxt = pc_r + 32'd1;
      case (opc)
        umrx_pkg::OPC_CMOV: begin
          we = (rc_r != '0);
          wd = rb_r;
        end
        umrx_pkg::OPC_LOAD: begin
          act       = umrx_pkg::ACT_READ;
          seg       = rb_r;
          off       = rc_r;
          pend_nxt  = fa;
          await_nxt = 1'b1;
        end
        umrx_pkg::OPC_STORE: begin
          act = umrx_pkg::ACT_WRITE;
          seg = ra_r;
          off = rb_r;
          dat = rc_r;
        end
        umrx_pkg::OPC_ADD: begin
          we = 1'b1;
          wd = rb_r + rc_r;
        end
        umrx_pkg::OPC_MUL: begin
          we = 1'b1;
          wd = prod;
        end
        umrx_pkg::OPC_DIV: begin
          if (rc_r == '0) begin
            act        = umrx_pkg::ACT_DIV0;
            halted_nxt = 1'b1;
            pc_nxt     = pc_r;
          end else begin
            we = 1'b1;
            wd = quot_r;
          end
        end
        umrx_pkg::OPC_NAND: begin
          we = 1'b1;
          wd = ~(rb_r & rc_r);
        end
        umrx_pkg::OPC_HALT: begin
          act        = umrx_pkg::ACT_HALT;
          halted_nxt = 1'b1;
          pc_nxt     = pc_r;
        end
        umrx_pkg::OPC_MAP: begin
          act       = umrx_pkg::ACT_MAP;
          seg       = rc_r;
          pend_nxt  = fb;
          await_nxt = 1'b1;
        end
        umrx_pkg::OPC_UNMAP: begin
          act = umrx_pkg::ACT_UNMAP;
          seg = rc_r;
        end
        umrx_pkg::OPC_OUT: begin
          if (rc_r > umrx_pkg::CHAR_MAX) begin
            act        = umrx_pkg::ACT_BADCHAR;
            halted_nxt = 1'b1;
            pc_nxt     = pc_r;
          end else begin
            act = umrx_pkg::ACT_OUT;
            dat = rc_r;
          end
        end
        umrx_pkg::OPC_IN: begin
          act       = umrx_pkg::ACT_IN;
          pend_nxt  = fc;
          await_nxt = 1'b1;
        end
        umrx_pkg::OPC_LOADPRG: begin
          act    = umrx_pkg::ACT_LOADPROG;
          seg    = rb_r;
          pc_nxt = rc_r;
        end
        umrx_pkg::OPC_LOADVAL: begin
          we = 1'b1;
          wa = flv;
          wd = {{(XL-umrx_pkg::LV_W){1'b0}}, instr_r[umrx_pkg::LV_W-1:0]};
        end
        default: begin
        end
      endcase
    end
  end

  // item capture, operands, divider and result fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_op;
      instr_r <= in_instruction;
      resp_r  <= in_response;
    end
    if (cmd.latch_bc) begin
      rb_r <= vld_r[fb] ? rd0 : '0;
      rc_r <= vld_r[fc] ? rd1 : '0;
    end
    if (cmd.latch_a) begin
      ra_r <= vld_r[fa] ? rd0 : '0;
    end
    if (cmd.div_start) begin
      quot_r    <= rb_r;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + 1'b1;
      if (!rem_diff[XL]) begin
        rem_r  <= rem_diff[XL-1:0];
        quot_r <= {quot_r[XL-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[XL-1:0];
        quot_r <= {quot_r[XL-2:0], 1'b0};
      end
    end
    if (cmd.commit) begin
      act_r <= act;
      seg_r <= seg;
      off_r <= off;
      dat_r <= dat;
      npc_r <= pc_nxt;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      pend_r      <= '0;
      await_r     <= 1'b0;
      halted_r    <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        pc_r     <= pc_nxt;
        pend_r   <= pend_nxt;
        await_r  <= await_nxt;
        halted_r <= halted_nxt;
        if (we) begin
          vld_r[wa] <= 1'b1;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_action      = act_r;
  assign out_segment_id  = seg_r;
  assign out_word_offset = off_r;
  assign out_data_value  = dat_r;
  assign out_next_pc     = npc_r;

  a_commit_presents: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed item not presented");

  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halted state cleared");

  a_await_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(await_r) |-> $past(cmd.commit))
    else $error("request pending without commit");

endmodule

// ===== rtl/core/um_register_execute_unit.sv =====
// ----------------------------------------------------------------------------
// um_register_execute_unit
// execute unit of a 14-opcode 32-bit universal machine
// ----------------------------------------------------------------------------
// Takes one item at a time: an instruction word or the response word for the
// pending load, map or input request, and returns exactly one result item per
// input item. An instruction reads its operands from an 8-entry register file
// ram with two registered read ports, b and c first and then a, and the unit is
// ready again in the same cycle as its result becomes valid. A divide also runs
// the radix-2 restoring divider. A response item or a rejected item skips the
// operand reads. The result sits in an output register, so the next item is
// accepted while it waits to be taken; that item then holds in its done state
// until the output register frees.
// ----------------------------------------------------------------------------
module um_register_execute_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // instruction[31:0], response[63:32]
  input  logic         in_tuser,   // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // segment_id, word_offset, data_value, next_pc
  output logic [3:0]   out_tuser   // action
);

  umrx_pkg::umrx_cmd_t cmd;
  umrx_pkg::umrx_sts_t sts;

  umrx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  umrx_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_tuser),
    .in_instruction  (in_tdata[31:0]),
    .in_response     (in_tdata[63:32]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_action      (out_tuser),
    .out_segment_id  (out_tdata[31:0]),
    .out_word_offset (out_tdata[63:32]),
    .out_data_value  (out_tdata[95:64]),
    .out_next_pc     (out_tdata[127:96])
  );

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the universal machine register execute unit
// ----------------------------------------------------------------------------
// Before each phase, a queue of instruction and response items is built while a
// behavioral copy of the machine (register file, pc, pending request, halt)
// works out the result of each one. The driver sends the items over the input
// stream and releases each item's expected result when it is accepted. The
// monitor compares every result against the oldest expected one. A directed
// opening covers the field extremes, every opcode but halt and the protocol cases.
// Random programs follow under four idle and stall mixes, and the run ends in
// one random halt, divide-by-zero or bad-character stop with items after it.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_EXEC = 1'b0;
  localparam logic OP_RESP = 1'b1;
  localparam logic [umrx_pkg::OPC_W-1:0] OPC_SPARE_E = 4'd14;
  localparam logic [umrx_pkg::OPC_W-1:0] OPC_SPARE_F = 4'd15;
  localparam int unsigned RANDOM_PER_PHASE = 350;

  typedef struct packed {
    logic                      op;
    logic [umrx_pkg::XLEN-1:0] instruction;
    logic [umrx_pkg::XLEN-1:0] response;
  } um_item_t;

  typedef struct packed {
    logic [umrx_pkg::ACT_W-1:0] action;
    logic [umrx_pkg::XLEN-1:0]  segment_id;
    logic [umrx_pkg::XLEN-1:0]  word_offset;
    logic [umrx_pkg::XLEN-1:0]  data_value;
    logic [umrx_pkg::XLEN-1:0]  next_pc;
  } um_result_t;

  typedef struct packed {
    um_item_t   item;
    um_result_t outcome;
  } um_job_t;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic [3:0]   out_tuser;

  // machine state as seen by the item generator
  logic [umrx_pkg::XLEN-1:0]   um_regs [umrx_pkg::NUM_REGS];
  logic [umrx_pkg::XLEN-1:0]   um_pc = '0;
  logic [umrx_pkg::RIDX_W-1:0] resp_dest = '0;
  logic                        resp_wait = 1'b0;
  logic                        machine_stopped = 1'b0;

  um_job_t     pending_items [$];
  um_result_t  expected_results [$];
  um_job_t     cur_job;
  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned mismatch_count = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;

  function automatic um_result_t execute_um(input um_item_t it);
    um_result_t                  res;
    logic [umrx_pkg::OPC_W-1:0]  opc;
    logic [umrx_pkg::RIDX_W-1:0] ra, rb, rc;
    logic                        advance;
    res = '0;
    advance = 1'b1;
    opc = it.instruction[umrx_pkg::OPC_LSB +: umrx_pkg::OPC_W];
    ra = it.instruction[8:6];
    rb = it.instruction[5:3];
    rc = it.instruction[2:0];
    if (it.op == OP_RESP) begin
      if (machine_stopped || !resp_wait) begin
        res.action = umrx_pkg::ACT_PROTOCOL;
      end else begin
        um_regs[resp_dest] = it.response;
        resp_wait = 1'b0;
      end
      res.next_pc = um_pc;
      return res;
    end
    if (machine_stopped || resp_wait) begin
      res.action = umrx_pkg::ACT_PROTOCOL;
      res.next_pc = um_pc;
      return res;
    end
    case (opc)
      umrx_pkg::OPC_CMOV: begin
        if (um_regs[rc] != '0) um_regs[ra] = um_regs[rb];
      end
      umrx_pkg::OPC_LOAD: begin
        res.action = umrx_pkg::ACT_READ;
        res.segment_id = um_regs[rb];
        res.word_offset = um_regs[rc];
        resp_dest = ra;
        resp_wait = 1'b1;
      end
      umrx_pkg::OPC_STORE: begin
        res.action = umrx_pkg::ACT_WRITE;
        res.segment_id = um_regs[ra];
        res.word_offset = um_regs[rb];
        res.data_value = um_regs[rc];
      end
      umrx_pkg::OPC_ADD: begin
        um_regs[ra] = um_regs[rb] + um_regs[rc];
      end
      umrx_pkg::OPC_MUL: begin
        um_regs[ra] = um_regs[rb] * um_regs[rc];
      end
      umrx_pkg::OPC_DIV: begin
        if (um_regs[rc] == '0) begin
          machine_stopped = 1'b1;
          res.action = umrx_pkg::ACT_DIV0;
          advance = 1'b0;
        end else begin
          um_regs[ra] = um_regs[rb] / um_regs[rc];
        end
      end
      umrx_pkg::OPC_NAND: begin
        um_regs[ra] = ~(um_regs[rb] & um_regs[rc]);
      end
      umrx_pkg::OPC_HALT: begin
        machine_stopped = 1'b1;
        res.action = umrx_pkg::ACT_HALT;
        advance = 1'b0;
      end
      umrx_pkg::OPC_MAP: begin
        res.action = umrx_pkg::ACT_MAP;
        res.segment_id = um_regs[rc];
        resp_dest = rb;
        resp_wait = 1'b1;
      end
      umrx_pkg::OPC_UNMAP: begin
        res.action = umrx_pkg::ACT_UNMAP;
        res.segment_id = um_regs[rc];
      end
      umrx_pkg::OPC_OUT: begin
        if (um_regs[rc] > umrx_pkg::CHAR_MAX) begin
          machine_stopped = 1'b1;
          res.action = umrx_pkg::ACT_BADCHAR;
          advance = 1'b0;
        end else begin
          res.action = umrx_pkg::ACT_OUT;
          res.data_value = um_regs[rc];
        end
      end
      umrx_pkg::OPC_IN: begin
        res.action = umrx_pkg::ACT_IN;
        resp_dest = rc;
        resp_wait = 1'b1;
      end
      umrx_pkg::OPC_LOADPRG: begin
        res.action = umrx_pkg::ACT_LOADPROG;
        res.segment_id = um_regs[rb];
        um_pc = um_regs[rc];
        advance = 1'b0;
      end
      umrx_pkg::OPC_LOADVAL: begin
        um_regs[it.instruction[umrx_pkg::LV_REG_LSB +: umrx_pkg::RIDX_W]] =
          {7'd0, it.instruction[umrx_pkg::LV_W-1:0]};
      end
      default: begin
      end
    endcase
    if (advance) um_pc = um_pc + 1'b1;
    res.next_pc = um_pc;
    return res;
  endfunction

  task automatic queue_item(input logic op, input logic [umrx_pkg::XLEN-1:0] instr,
                            input logic [umrx_pkg::XLEN-1:0] resp);
    um_job_t job;
    job.item.op = op;
    job.item.instruction = instr;
    job.item.response = resp;
    job.outcome = execute_um(job.item);
    pending_items.push_back(job);
    queued_total++;
  endtask

  function automatic logic [umrx_pkg::XLEN-1:0] rrr(input logic [umrx_pkg::OPC_W-1:0] opc,
                                                    input logic [2:0] a,
                                                    input logic [2:0] b,
                                                    input logic [2:0] c);
    return {opc, 19'd0, a, b, c};
  endfunction

  function automatic logic [umrx_pkg::XLEN-1:0] lv(input logic [2:0] r,
                                                   input logic [umrx_pkg::LV_W-1:0] v);
    return {umrx_pkg::OPC_LOADVAL, r, v};
  endfunction

  function automatic logic [umrx_pkg::XLEN-1:0] rand_word();
    case ($urandom_range(7))
      0, 1: return $urandom_range(255);
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // divide or output that would stop the machine
  function automatic logic stops_machine(input logic [umrx_pkg::XLEN-1:0] w);
    return (w[umrx_pkg::OPC_LSB +: umrx_pkg::OPC_W] == umrx_pkg::OPC_DIV &&
            um_regs[w[2:0]] == '0) ||
           (w[umrx_pkg::OPC_LSB +: umrx_pkg::OPC_W] == umrx_pkg::OPC_OUT &&
            um_regs[w[2:0]] > umrx_pkg::CHAR_MAX);
  endfunction

  function automatic logic [umrx_pkg::XLEN-1:0] random_instruction();
    logic [umrx_pkg::XLEN-1:0] w;
    logic [umrx_pkg::XLEN-1:0] v;
    int                        k;
    w = $urandom;
    if ($urandom_range(3) == 0 ||
        w[umrx_pkg::OPC_LSB +: umrx_pkg::OPC_W] == umrx_pkg::OPC_HALT) begin
      w[umrx_pkg::OPC_LSB +: umrx_pkg::OPC_W] = umrx_pkg::OPC_LOADVAL;
    end
    if (w[umrx_pkg::OPC_LSB +: umrx_pkg::OPC_W] == umrx_pkg::OPC_LOADVAL &&
        $urandom_range(1) == 0) begin
      v = rand_word();
      w[umrx_pkg::LV_W-1:0] = v[umrx_pkg::LV_W-1:0];
    end
    for (k = 0; k < umrx_pkg::NUM_REGS && stops_machine(w); k++) w[2:0] = w[2:0] + 3'd1;
    if (stops_machine(w)) w[umrx_pkg::OPC_LSB +: umrx_pkg::OPC_W] = umrx_pkg::OPC_LOADVAL;
    return w;
  endfunction

  task automatic queue_directed();
    queue_item(OP_RESP, $urandom, '1);
    queue_item(OP_EXEC, lv(7, 25'h1FF_FFFF), '0);
    queue_item(OP_EXEC, lv(2, 25'd3), $urandom);
    queue_item(OP_EXEC, rrr(umrx_pkg::OPC_NAND, 3, 1, 1), $urandom);
    queue_item(OP_EXEC, rrr(umrx_pkg::OPC_ADD, 4, 3, 3), $urandom);
    queue_item(OP_EXEC, rrr(umrx_pkg::OPC_MUL, 5, 3, 3), $urandom);
    queue_item(OP_EXEC, rrr(umrx_pkg::OPC_DIV, 6, 3, 2), $urandom);
    queue_item(OP_EXEC, rrr(umrx_pkg::OPC_CMOV, 0, 3, 1), $urandom);
    queue_item(OP_EXEC, rrr(umrx_pkg::OPC_CMOV, 0, 3, 2), $urandom);
    queue_item(OP_EXEC, rrr(umrx_pkg::OPC_STORE, 0, 3, 7), $urandom);
    queue_item(OP_EXEC, rrr(umrx_pkg::OPC_UNMAP, 0, 0, 7), $urandom);
    queue_item(OP_EXEC, lv(1, 25'd255), $urandom);
    queue_item(OP_EXEC, rrr(umrx_pkg::OPC_OUT, 0, 0, 1), $urandom);
    queue_item(OP_EXEC, lv(1, 25'd0), $urandom);
    queue_item(OP_EXEC, rrr(umrx_pkg::OPC_OUT, 0, 0, 1), $urandom);
    // instruction while a load is outstanding
    queue_item(OP_EXEC, rrr(umrx_pkg::OPC_LOAD, 5, 3, 7), $urandom);
    queue_item(OP_EXEC, '1, $urandom);
    queue_item(OP_RESP, $urandom, '1);
    queue_item(OP_EXEC, rrr(umrx_pkg::OPC_MAP, 0, 4, 2), $urandom);
    queue_item(OP_RESP, $urandom, '0);
    queue_item(OP_EXEC, rrr(umrx_pkg::OPC_IN, 0, 0, 6), $urandom);
    queue_item(OP_RESP, $urandom, '1);
    queue_item(OP_EXEC, {OPC_SPARE_E, 28'hFFF_FFFF}, $urandom);
    queue_item(OP_EXEC, {OPC_SPARE_F, 28'hFFF_FFFF}, $urandom);
    // jump only, then a real program load
    queue_item(OP_EXEC, rrr(umrx_pkg::OPC_LOADPRG, 0, 1, 2), $urandom);
    queue_item(OP_EXEC, rrr(umrx_pkg::OPC_LOADPRG, 0, 3, 7), $urandom);
  endtask

  task automatic queue_random(input int unsigned n);
    int unsigned               made;
    logic [umrx_pkg::XLEN-1:0] w;
    made = 0;
    while (made < n) begin
      if (resp_wait) begin
        if ($urandom_range(99) < 10) begin
          queue_item(OP_EXEC, $urandom, $urandom);
        end else begin
          queue_item(OP_RESP, $urandom, rand_word());
          made++;
        end
      end else if ($urandom_range(99) < 4) begin
        queue_item(OP_RESP, $urandom, $urandom);
      end else begin
        w = random_instruction();
        queue_item(OP_EXEC, w, $urandom);
        if (w[umrx_pkg::OPC_LSB +: umrx_pkg::OPC_W] < OPC_SPARE_E) made++;
      end
    end
    if (resp_wait) queue_item(OP_RESP, $urandom, rand_word());
  endtask

  // one machine stop, then items that must all be refused
  task automatic queue_stop();
    logic [2:0]                r;
    logic [umrx_pkg::XLEN-1:0] w;
    r = 3'($urandom);
    w = $urandom;
    case ($urandom_range(2))
      0: begin
        w[umrx_pkg::OPC_LSB +: umrx_pkg::OPC_W] = umrx_pkg::OPC_HALT;
        queue_item(OP_EXEC, w, $urandom);
      end
      1: begin
        queue_item(OP_EXEC, lv(r, 25'd0), $urandom);
        queue_item(OP_EXEC, rrr(umrx_pkg::OPC_DIV, w[8:6], w[5:3], r), $urandom);
      end
      default: begin
        queue_item(OP_EXEC, lv(r, umrx_pkg::LV_W'(256 + $urandom_range(32'h1FF_FEFF))),
                   $urandom);
        queue_item(OP_EXEC, rrr(umrx_pkg::OPC_OUT, 0, 0, r), $urandom);
      end
    endcase
    queue_item(OP_EXEC, random_instruction(), $urandom);
    queue_item(OP_RESP, $urandom, $urandom);
    queue_item(OP_EXEC, lv(r, 25'd1), $urandom);
    queue_item(OP_RESP, $urandom, $urandom);
  endtask

  um_register_execute_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(cur_job.outcome);
        accepted_total++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          cur_job = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {cur_job.item.response, cur_job.item.instruction};
          in_tuser <= cur_job.item.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    um_result_t want;
    um_result_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_stall_pct);
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
               out_tdata[127:96]};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected item act %0d seg %h off %h data %h pc %h", $time,
                   got.action, got.segment_id, got.word_offset, got.data_value, got.next_pc);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            $display("%0t: expected act %0d seg %h off %h data %h pc %h", $time,
                     want.action, want.segment_id, want.word_offset, want.data_value,
                     want.next_pc);
            $display("%0t: actual   act %0d seg %h off %h data %h pc %h", $time,
                     got.action, got.segment_id, got.word_offset, got.data_value, got.next_pc);
          end
        end
      end
    end
  end

  initial begin
    int phase;
    for (int i = 0; i < umrx_pkg::NUM_REGS; i++) um_regs[i] = '0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          in_idle_pct = 0;
          out_stall_pct = 0;
          queue_directed();
        end
        1: begin
          in_idle_pct = 49;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct = 0;
          out_stall_pct = 49;
        end
        default: begin
          in_idle_pct = 12;
          out_stall_pct = 12;
        end
      endcase
      queue_random(RANDOM_PER_PHASE);
      if (phase == 3) queue_stop();
      while (accepted_total != queued_total || expected_results.size() != 0) @(posedge clk);
    end
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("um_register_execute_unit: match");
    end else begin
      $display("um_register_execute_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("um_register_execute_unit: mismatch");
    $finish;
  end

endmodule
